>>> hdl/priority_fifo_task_scheduler_unit_defines.svh
// assertion macros used by the checker file
// clk and rst_n must be visible where a macro is used
`ifndef PRIORITY_FIFO_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define PRIORITY_FIFO_TASK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define PFTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pfts_pkg.sv
// ----------------------------------------------------------------------------
// pfts_pkg
// shared constants, request and status codes and the result word type
// ----------------------------------------------------------------------------
package pfts_pkg;

    localparam int PRIO_LEVELS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF  = 64;
    localparam int TASK_ID_BITS_DEF = 16;

    localparam int REQ_W    = 2;
    localparam int PRIO_W   = 4;
    localparam int TASK_W   = 16;
    localparam int STATUS_W = 3;

    localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_QUEUED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REF_STOPPED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REF_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SERVED      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_STOPPED     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SHUTDOWN    = 3'd6;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TASK_W-1:0]   task_id;
        logic [PRIO_W-1:0]   prio;
    } pfts_res_t;

endpackage

>>> hdl/pfts_ram.sv
// ----------------------------------------------------------------------------
// pfts_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pfts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/pfts_out_buf.sv
// ----------------------------------------------------------------------------
// pfts_out_buf
// two-word output buffer: output register plus one skid entry
// ----------------------------------------------------------------------------
module pfts_out_buf
    import pfts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pfts_res_t push_res,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output pfts_res_t out_res
);

    logic      out_valid_reg;
    logic      pend_valid_reg;
    pfts_res_t out_res_reg;
    pfts_res_t pend_res_reg;
    logic      pop;

    assign pop       = out_valid_reg && out_ready;
    assign room      = !pend_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg  <= pend_valid_reg || push;
                pend_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_res_reg <= pend_valid_reg ? pend_res_reg : push_res;
        end
        if (push)
        begin
            pend_res_reg <= push_res;
        end
    end

endmodule

>>> hdl/priority_fifo_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_fifo_task_scheduler_unit
// per-level task fifos kept as linked chains in a shared entry store
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) takes one request word: enqueue,
//   dequeue or shutdown. output channel (out_valid/out_ready) returns one
//   result word per request, in request order.
//   the result of a stored enqueue is pushed to the output buffer from the
//   enqueue state, that of a serving dequeue from the second dequeue state,
//   and every refused or empty answer and shutdown straight from idle.
//   a new request is taken only in idle: enqueue waits in its state for the
//   entry store read of the chain link, and dequeue for the head lookup and
//   then for that read; requests for the other answers are taken every cycle
//   while the output buffer has room.
//   after reset the queue is empty and ready at once: untouched entries of
//   the free chain are tracked by a fill mark, so there is no clearing pass.
//   a stalled receiver is absorbed by a two-word output buffer; once both
//   words are held, in_ready stays low until the receiver takes one.
// ----------------------------------------------------------------------------
module priority_fifo_task_scheduler_unit
    import pfts_pkg::*;
#(
    parameter int PRIO_LEVELS  = PRIO_LEVELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [PRIO_W-1:0]   priority_req,
    input  logic [TASK_W-1:0]   task_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [TASK_W-1:0]   served_task,
    output logic [PRIO_W-1:0]   served_priority
);

    localparam int LVL_W = $clog2(PRIO_LEVELS);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ENQ   = 4'b0010,
        S_DEQ_A = 4'b0100,
        S_DEQ_B = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PRIO_LEVELS-1:0]  busy_reg, busy_next;
    logic [IDX_W-1:0]        free_head_reg, free_head_next;
    logic [CNT_W-1:0]        used_reg, used_next;
    logic [CNT_W-1:0]        fresh_reg, fresh_next;
    logic                    started_reg, started_next;
    logic                    stopped_reg, stopped_next;

    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    virt_reg, virt_next;
    logic                    last_reg, last_next;

    logic                    accept;
    logic                    room;
    logic                    push;
    pfts_res_t               push_res;
    pfts_res_t               out_res;

    logic [LVL_W-1:0]        lvl_in;
    logic [LVL_W-1:0]        lowest;
    logic                    any_busy;
    logic [IDX_W-1:0]        idx_wrap;

    logic                    task_we;
    logic [TASK_ID_BITS-1:0] task_rd;
    logic                    link_we;
    logic [IDX_W-1:0]        link_waddr, link_wdata, link_raddr, link_rd;
    logic                    head_we;
    logic [LVL_W-1:0]        head_waddr;
    logic [IDX_W-1:0]        head_wdata, head_rd;
    logic                    tail_we;
    logic [LVL_W-1:0]        tail_raddr;
    logic [IDX_W-1:0]        tail_rd;

    assign in_ready = (state_reg == S_IDLE) && room;
    assign accept   = in_valid && in_ready;

    // priority beyond the last level saturates
    assign lvl_in = (32'(priority_req) >= 32'(PRIO_LEVELS)) ?
                    LVL_W'(PRIO_LEVELS - 1) : LVL_W'(priority_req);

    assign idx_wrap = (idx_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx_reg + 1'b1;

    // lowest non-empty level
    always_comb
    begin
        lowest   = '0;
        any_busy = |busy_reg;
        for (int i = PRIO_LEVELS - 1; i >= 0; i--)
        begin
            if (busy_reg[i])
            begin
                lowest = LVL_W'(i);
            end
        end
    end

    assign link_raddr = (state_reg == S_DEQ_A) ? head_rd : free_head_reg;
    assign tail_raddr = (req_type == REQ_ENQ) ? lvl_in : lowest;

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        free_head_next = free_head_reg;
        used_next      = used_reg;
        fresh_next     = fresh_reg;
        started_next   = started_reg;
        stopped_next   = stopped_reg;
        lvl_next       = lvl_reg;
        idx_next       = idx_reg;
        virt_next      = virt_reg;
        last_next      = last_reg;
        task_we        = 1'b0;
        link_we        = 1'b0;
        link_waddr     = idx_reg;
        link_wdata     = idx_reg;
        head_we        = 1'b0;
        head_waddr     = lvl_reg;
        head_wdata     = idx_reg;
        tail_we        = 1'b0;
        push           = 1'b0;
        push_res       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_ENQ:
                        begin
                            if (stopped_reg)
                            begin
                                push            = 1'b1;
                                push_res.status = ST_REF_STOPPED;
                            end
                            else
                            begin
                                started_next = 1'b1;
                                if (used_reg >= CNT_W'(QUEUE_DEPTH))
                                begin
                                    push            = 1'b1;
                                    push_res.status = ST_REF_FULL;
                                end
                                else
                                begin
                                    task_we    = 1'b1;
                                    lvl_next   = lvl_in;
                                    idx_next   = free_head_reg;
                                    // untouched entry: next free index is implied, not read
                                    virt_next  = CNT_W'(free_head_reg) >= fresh_reg;
                                    state_next = S_ENQ;
                                end
                            end
                        end
                        REQ_DEQ:
                        begin
                            if (stopped_reg)
                            begin
                                push            = 1'b1;
                                push_res.status = ST_STOPPED;
                            end
                            else if (!any_busy)
                            begin
                                push            = 1'b1;
                                push_res.status = ST_NONE;
                            end
                            else
                            begin
                                lvl_next   = lowest;
                                state_next = S_DEQ_A;
                            end
                        end
                        REQ_STOP:
                        begin
                            push = 1'b1;
                            if (started_reg)
                            begin
                                started_next    = 1'b0;
                                stopped_next    = 1'b1;
                                push_res.status = ST_SHUTDOWN;
                            end
                            else
                            begin
                                push_res.status = stopped_reg ? ST_STOPPED : ST_NONE;
                            end
                        end
                        default:
                        begin
                            push            = 1'b1;
                            push_res.status = ST_NONE;
                        end
                    endcase
                end
            end
            S_ENQ:
            begin
                if (busy_reg[lvl_reg])
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_rd;
                    link_wdata = idx_reg;
                end
                else
                begin
                    head_we = 1'b1;
                end
                tail_we            = 1'b1;
                busy_next[lvl_reg] = 1'b1;
                free_head_next     = virt_reg ? idx_wrap : link_rd;
                if (virt_reg)
                begin
                    fresh_next = fresh_reg + CNT_W'(1);
                end
                used_next       = used_reg + CNT_W'(1);
                push            = 1'b1;
                push_res.status = ST_QUEUED;
                state_next      = S_IDLE;
            end
            S_DEQ_A:
            begin
                idx_next   = head_rd;
                last_next  = (head_rd == tail_rd);
                state_next = S_DEQ_B;
            end
            S_DEQ_B:
            begin
                link_we    = 1'b1;
                link_waddr = idx_reg;
                link_wdata = free_head_reg;
                if (last_reg)
                begin
                    busy_next[lvl_reg] = 1'b0;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = link_rd;
                end
                free_head_next   = idx_reg;
                used_next        = used_reg - CNT_W'(1);
                push             = 1'b1;
                push_res.status  = ST_SERVED;
                push_res.task_id = TASK_W'(task_rd);
                push_res.prio    = PRIO_W'(lvl_reg);
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            free_head_reg <= '0;
            used_reg      <= '0;
            fresh_reg     <= '0;
            started_reg   <= 1'b0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            free_head_reg <= free_head_next;
            used_reg      <= used_next;
            fresh_reg     <= fresh_next;
            started_reg   <= started_next;
            stopped_reg   <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg  <= lvl_next;
        idx_reg  <= idx_next;
        virt_reg <= virt_next;
        last_reg <= last_next;
    end

    pfts_ram #(
        .WIDTH (TASK_ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_task_ram (
        .clk   (clk),
        .we    (task_we),
        .waddr (free_head_reg),
        .wdata (TASK_ID_BITS'(task_id)),
        .raddr (head_rd),
        .rdata (task_rd)
    );

    pfts_ram #(
        .WIDTH (IDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rd)
    );

    pfts_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PRIO_LEVELS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (lowest),
        .rdata (head_rd)
    );

    pfts_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PRIO_LEVELS)
    ) u_tail_ram (
        .clk   (clk),
        .we    (tail_we),
        .waddr (lvl_reg),
        .wdata (idx_reg),
        .raddr (tail_raddr),
        .rdata (tail_rd)
    );

    pfts_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status          = out_res.status;
    assign served_task     = out_res.task_id;
    assign served_priority = out_res.prio;

endmodule

>>> hdl/pfts_chk.sv
// ----------------------------------------------------------------------------
// pfts_chk
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "priority_fifo_task_scheduler_unit_defines.svh"

module pfts_chk
    import pfts_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [TASK_W-1:0]   served_task,
    input logic [PRIO_W-1:0]   served_priority
);

    logic seen_stop_reg;

    // set once a shutdown word has left the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_stop_reg <= 1'b0;
        end
        else if (out_valid && out_ready && status == ST_SHUTDOWN)
        begin
            seen_stop_reg <= 1'b1;
        end
    end

    `PFTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(served_task) && $stable(served_priority), "output word changed while stalled")

    `PFTS_ASSERT_NOW(a_zero_fields, out_valid && status != ST_SERVED, served_task == '0 && served_priority == '0, "task fields set on a word that serves nothing")

    `PFTS_ASSERT_NOW(a_no_work_after_stop, seen_stop_reg && out_valid, status != ST_QUEUED && status != ST_SERVED, "task queued or served after shutdown")

endmodule

bind priority_fifo_task_scheduler_unit pfts_chk u_pfts_chk (.*);
